[hw/rtl/awdt_pkg.sv]
// awdt_pkg: shared widths, opcodes, decoded item type and helper functions
// for the alu_with_definedness_tracking block. No dependencies.
package awdt_pkg;

	localparam int DW = 64;                 // data field width
	localparam int WW = 7;                  // width field width
	localparam int MAX_WIDTH = 64;
	localparam int LIMIT_WIDTH = (MAX_WIDTH < DW) ? MAX_WIDTH : DW;
	localparam int DIV_STEPS = DW;          // one quotient bit per stage
	localparam int HW = DW / 2;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_MUL  = 5'd2,
		OP_DIVU = 5'd3,
		OP_DIVS = 5'd4,
		OP_MODU = 5'd5,
		OP_MODS = 5'd6,
		OP_SHL  = 5'd7,
		OP_SHR  = 5'd8,
		OP_SHRS = 5'd9,
		OP_AND  = 5'd10,
		OP_OR   = 5'd11,
		OP_XOR  = 5'd12,
		OP_NOT  = 5'd13,
		OP_ZX   = 5'd14,
		OP_SX   = 5'd15,
		OP_EQ   = 5'd16,
		OP_NEQ  = 5'd17,
		OP_LES  = 5'd18,
		OP_LEU  = 5'd19,
		OP_LTS  = 5'd20,
		OP_LTU  = 5'd21
	} op_t;

	// item after the front: widths clamped, operands masked, divider inputs ready
	typedef struct packed {
		op_t            op;
		logic [WW-1:0]  w;
		logic [WW-1:0]  tw;
		logic [DW-1:0]  m;
		logic [DW-1:0]  a;
		logic [DW-1:0]  b;
		logic [DW-1:0]  da;
		logic [DW-1:0]  db;
		logic [DW-1:0]  ua;
		logic [DW-1:0]  ub;
		logic           sa;
		logic           sb;
	} dec_t;

	// state that rides along the back pipeline next to the divider
	typedef struct packed {
		op_t            op;
		logic [WW-1:0]  rw;
		logic [DW-1:0]  m;
		logic [DW-1:0]  val;
		logic [DW-1:0]  def;
		logic           dz;
		logic           sa;
		logic           sb;
	} side_t;

	function automatic logic [DW-1:0] low_mask(input logic [WW-1:0] n);
		if (n >= WW'(DW))
			return '1;
		return (DW'(1) << n) - DW'(1);
	endfunction

	function automatic logic [WW-1:0] clamp_width(input logic [WW-1:0] x);
		return (x > WW'(LIMIT_WIDTH)) ? WW'(LIMIT_WIDTH) : x;
	endfunction

	function automatic logic top_bit(input logic [DW-1:0] v, input logic [WW-1:0] w);
		logic [DW-1:0] t;
		t = v >> (w - WW'(1));
		return (w != '0) ? t[0] : 1'b0;
	endfunction

	// defined up to the lowest undefined bit
	function automatic logic [DW-1:0] carry_defined(input logic [DW-1:0] both,
			input logic [DW-1:0] m);
		logic [DW-1:0] u;
		u = ~both & m;
		if (u == '0)
			return m;
		return ((u & (DW'(0) - u)) - DW'(1)) & m;
	endfunction

endpackage

[hw/rtl/awdt_req_if.sv]
// awdt_req_if: request channel, valid/ready plus the request fields
// depends on awdt_pkg
interface awdt_req_if import awdt_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [4:0]     req_type;
	logic [WW-1:0]  width;
	logic [WW-1:0]  target_width;
	logic [DW-1:0]  operand_a;
	logic [DW-1:0]  defined_a;
	logic [DW-1:0]  operand_b;
	logic [DW-1:0]  defined_b;

	modport source (output valid, req_type, width, target_width, operand_a, defined_a,
		operand_b, defined_b, input ready);
	modport sink (input valid, req_type, width, target_width, operand_a, defined_a,
		operand_b, defined_b, output ready);
endinterface

[hw/rtl/awdt_rsp_if.sv]
// awdt_rsp_if: result channel, valid/ready plus the result fields
// depends on awdt_pkg
interface awdt_rsp_if import awdt_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [DW-1:0]  result_value;
	logic [DW-1:0]  result_defined;
	logic [WW-1:0]  result_width;
	logic           divide_by_zero;

	modport source (output valid, result_value, result_defined, result_width,
		divide_by_zero, input ready);
	modport sink (input valid, result_value, result_defined, result_width,
		divide_by_zero, output ready);
endinterface

[hw/rtl/awdt_front.sv]
// awdt_front: accepts requests, clamps widths, masks operands and prepares
// divider magnitudes; depends on awdt_pkg and awdt_req_if
module awdt_front import awdt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	awdt_req_if.sink      req,
	output dec_t          dec,
	output logic          dec_valid,
	input  logic          dec_ready
);

	dec_t dec_q;
	logic valid_q;
	dec_t nxt;
	op_t  op;
	logic is_signed;

	assign req.ready = !valid_q || dec_ready;
	assign dec = dec_q;
	assign dec_valid = valid_q;

	always_comb begin
		op = op_t'(req.req_type);
		nxt.op = op;
		nxt.w = clamp_width(req.width);
		nxt.tw = clamp_width(req.target_width);
		nxt.m = low_mask(nxt.w);
		nxt.a = req.operand_a & nxt.m;
		nxt.b = req.operand_b & nxt.m;
		nxt.da = req.defined_a & nxt.m;
		nxt.db = req.defined_b & nxt.m;
		is_signed = (op == OP_DIVS) || (op == OP_MODS);
		nxt.sa = is_signed && top_bit(nxt.a, nxt.w);
		nxt.sb = is_signed && top_bit(nxt.b, nxt.w);
		nxt.ua = nxt.sa ? ((DW'(0) - nxt.a) & nxt.m) : nxt.a;
		nxt.ub = nxt.sb ? ((DW'(0) - nxt.b) & nxt.m) : nxt.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_q <= 1'b1;
		end else if (dec_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			dec_q <= nxt;
		end
	end

endmodule

[hw/rtl/awdt_fifo.sv]
// awdt_fifo: two-entry queue of decoded items between front and back
// depends on awdt_pkg
module awdt_fifo import awdt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dec_t in_data,
	input  logic in_valid,
	output logic in_ready,
	output dec_t out_data,
	output logic out_valid,
	input  logic out_ready
);

	dec_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_data;
	end

endmodule

[hw/rtl/awdt_back.sv]
// awdt_back: execution pipeline, simple ops and multiplier partial products,
// then one restoring divide step per stage, then the output register
// depends on awdt_pkg and awdt_rsp_if
module awdt_back import awdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dec_t      hd,
	input  logic      hd_valid,
	output logic      hd_ready,
	awdt_rsp_if.source rsp
);

	logic en;

	// stage 1 results
	side_t          side1;
	logic [DW-1:0]  both;
	logic           allm;
	logic [DW-1:0]  flip;
	logic [WW-1:0]  from;
	logic [DW-1:0]  fm;
	logic [DW-1:0]  hi;
	logic [DW-1:0]  fill;
	logic           shift_out;

	// pipeline, index 0 is stage 1
	logic           vld_s  [DIV_STEPS+1];
	side_t          side_s [DIV_STEPS+1];
	logic [DW-1:0]  rem_s  [DIV_STEPS+1];
	logic [DW-1:0]  qd_s   [DIV_STEPS+1];
	logic [DW-1:0]  dvs_s  [DIV_STEPS+1];
	logic [DW-1:0]  pp_ll_s1;
	logic [HW-1:0]  pp_lh_s1;
	logic [HW-1:0]  pp_hl_s1;

	logic           out_valid_q;
	logic [DW-1:0]  out_val_q;
	logic [DW-1:0]  out_def_q;
	logic [WW-1:0]  out_rw_q;
	logic           out_dz_q;

	side_t          last;
	logic [DW-1:0]  fin_val;
	logic [DW-1:0]  fin_def;
	logic [DW-1:0]  rmask;

	assign en = !out_valid_q || rsp.ready;
	assign hd_ready = en;

	always_comb begin
		both = hd.da & hd.db;
		allm = (both == hd.m);
		flip = (hd.w != '0) ? (DW'(1) << (hd.w - WW'(1))) : '0;
		from = (hd.w < hd.tw) ? hd.w : hd.tw;
		fm = low_mask(from);
		hi = low_mask(hd.tw) & ~fm;
		fill = ((hd.op == OP_SHRS) && top_bit(hd.a, hd.w)) ? hd.m : '0;
		shift_out = (hd.b >= DW'(hd.w));

		side1.op = hd.op;
		side1.rw = hd.w;
		side1.m = hd.m;
		side1.val = '0;
		side1.def = allm ? hd.m : '0;
		side1.dz = 1'b0;
		side1.sa = hd.sa;
		side1.sb = hd.sb;

		unique case (hd.op)
			OP_ADD: begin
				side1.val = hd.a + hd.b;
				side1.def = carry_defined(both, hd.m);
			end
			OP_SUB: begin
				side1.val = hd.a - hd.b;
				side1.def = carry_defined(both, hd.m);
			end
			OP_MUL: ;
			OP_DIVU, OP_DIVS, OP_MODU, OP_MODS: begin
				side1.dz = (hd.b == '0);
			end
			OP_SHL: begin
				side1.val = shift_out ? '0 : (hd.a << hd.b);
				side1.def = both;
			end
			OP_SHR, OP_SHRS: begin
				side1.val = shift_out ? fill : ((hd.a >> hd.b) | (fill & ~(hd.m >> hd.b)));
			end
			OP_AND: begin
				side1.val = hd.a & hd.b;
				side1.def = both;
			end
			OP_OR: begin
				side1.val = hd.a | hd.b;
				side1.def = both;
			end
			OP_XOR: begin
				side1.val = hd.a ^ hd.b;
				side1.def = both;
			end
			OP_NOT: begin
				side1.val = ~hd.a;
				side1.def = hd.da;
			end
			OP_ZX: begin
				side1.rw = hd.tw;
				side1.val = hd.a & fm;
				side1.def = (hd.da & fm) | hi;
			end
			OP_SX: begin
				side1.rw = hd.tw;
				side1.val = '0;
				side1.def = '0;
				if (hd.w != '0 && hd.tw != '0) begin
					side1.val = (hd.a & fm) | (top_bit(hd.a, from) ? hi : '0);
					side1.def = (hd.da & fm) | (top_bit(hd.da, from) ? hi : '0);
				end
			end
			OP_EQ, OP_NEQ, OP_LES, OP_LEU, OP_LTS, OP_LTU: begin
				side1.rw = WW'(1);
				side1.def = DW'(allm);
				unique case (hd.op)
					OP_EQ:   side1.val = DW'((hd.a & hd.da) == (hd.b & hd.db));
					OP_NEQ:  side1.val = DW'((hd.a & hd.da) != (hd.b & hd.db));
					OP_LES:  side1.val = DW'((hd.a ^ flip) <= (hd.b ^ flip));
					OP_LEU:  side1.val = DW'(hd.a <= hd.b);
					OP_LTS:  side1.val = DW'((hd.a ^ flip) < (hd.b ^ flip));
					default: side1.val = DW'(hd.a < hd.b);
				endcase
			end
			default: begin
				side1.rw = '0;
				side1.def = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= hd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side1;
			rem_s[0] <= '0;
			qd_s[0] <= hd.ua;
			dvs_s[0] <= hd.ub;
			pp_ll_s1 <= hd.a[HW-1:0] * hd.b[HW-1:0];
			pp_lh_s1 <= HW'(hd.a[HW-1:0] * hd.b[DW-1:HW]);
			pp_hl_s1 <= HW'(hd.a[DW-1:HW] * hd.b[HW-1:0]);
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DW:0]   trial;
		logic          take;
		logic [DW-1:0] rem_n;
		side_t         side_n;

		always_comb begin
			trial = {rem_s[k], qd_s[k][DW-1]} - {1'b0, dvs_s[k]};
			take = !trial[DW];
			rem_n = take ? trial[DW-1:0] : {rem_s[k][DW-2:0], qd_s[k][DW-1]};
			side_n = side_s[k];
			// product is summed once, in the first step
			if (k == 0 && side_s[k].op == OP_MUL)
				side_n.val = pp_ll_s1 + {pp_lh_s1 + pp_hl_s1, HW'(0)};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_n;
				rem_s[k+1] <= rem_n;
				qd_s[k+1] <= {qd_s[k][DW-2:0], take};
				dvs_s[k+1] <= dvs_s[k];
			end
		end
	end

	always_comb begin
		last = side_s[DIV_STEPS];
		fin_val = last.val;
		fin_def = last.def;
		unique case (last.op)
			OP_DIVU: fin_val = qd_s[DIV_STEPS];
			OP_MODU: fin_val = rem_s[DIV_STEPS];
			OP_DIVS: fin_val = ((last.sa ^ last.sb) ? (DW'(0) - qd_s[DIV_STEPS])
				: qd_s[DIV_STEPS]) & last.m;
			OP_MODS: fin_val = (last.sa ? (DW'(0) - rem_s[DIV_STEPS])
				: rem_s[DIV_STEPS]) & last.m;
			default: ;
		endcase
		if (last.dz) begin
			fin_val = '0;
			fin_def = '0;
		end
		rmask = low_mask(last.rw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_val_q <= fin_val & rmask;
			out_def_q <= fin_def & rmask;
			out_rw_q <= last.rw;
			out_dz_q <= last.dz;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.result_value = out_val_q;
	assign rsp.result_defined = out_def_q;
	assign rsp.result_width = out_rw_q;
	assign rsp.divide_by_zero = out_dz_q;

endmodule

[hw/rtl/alu_with_definedness_tracking.sv]
// alu_with_definedness_tracking: top level, front, queue and back
// depends on awdt_pkg, awdt_req_if, awdt_rsp_if, awdt_front, awdt_fifo, awdt_back
//
// An ALU over values of up to 64 bits that carries a per-bit defined mask
// with every operand and result.
// Channels: req takes one operation per transfer (opcode, widths, two
// operands and their defined masks); rsp gives exactly one result per
// request, in request order (value, defined mask, width, divide-by-zero).
// Path from a req transfer to rsp valid: the front register loads at the
// transfer, then queue, first execute stage, 64 divider stages (one
// quotient bit each), output register. Every operation takes the same
// path.
// Throughput: one request per cycle while rsp does not stall; the multiplier
// is split into 32-bit partial products and the divider is fully pipelined.
// Reset: arst_n clears all valid bits and queue pointers; no transfer is
// pending afterwards and req is ready in the first cycle.
// Stall: when rsp is not taken the back pipeline holds as a whole; the
// two-entry queue and the front register absorb items until req.ready
// drops, so no item is lost or repeated.
module alu_with_definedness_tracking import awdt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	awdt_req_if.sink   req,
	awdt_rsp_if.source rsp
);

	dec_t front_dec;
	logic front_valid;
	logic front_ready;
	dec_t head;
	logic head_valid;
	logic head_ready;

	awdt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.dec       (front_dec),
		.dec_valid (front_valid),
		.dec_ready (front_ready)
	);

	awdt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (front_dec),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_data  (head),
		.out_valid (head_valid),
		.out_ready (head_ready)
	);

	awdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.hd       (head),
		.hd_valid (head_valid),
		.hd_ready (head_ready),
		.rsp      (rsp)
	);

endmodule

[dv/tb_alu_with_definedness_tracking.sv]
// tb_alu_with_definedness_tracking: self-checking testbench for the definedness-tracking alu
// depends on awdt_pkg, awdt_req_if, awdt_rsp_if and alu_with_definedness_tracking
module tb_alu_with_definedness_tracking;
	import awdt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] value;
		logic [63:0] defined;
		logic [6:0]  rwidth;
		logic        dz;
	} alu_result_t;

	class alu_scoreboard;
		alu_result_t pending[$];
		int errors;
		int checked;

		function automatic logic [63:0] ones_below(int n);
			return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
		endfunction

		function automatic logic [63:0] defined_to_first_hole(logic [63:0] both,
				logic [63:0] m);
			logic [63:0] u;
			u = ~both & m;
			if (u == 0)
				return m;
			return ((u & -u) - 64'd1) & m;
		endfunction

		function automatic logic sign_at(logic [63:0] v, int w);
			return (w == 0) ? 1'b0 : v[w-1];
		endfunction

		function automatic alu_result_t compute(logic [4:0] code, logic [6:0] wi,
				logic [6:0] twi, logic [63:0] ai, logic [63:0] dai, logic [63:0] bi,
				logic [63:0] dbi);
			alu_result_t r;
			int w, tw, rw, from;
			logic [63:0] m, a, b, da, db, both, all, val, def, fill, fm, hi;
			logic [63:0] ua, ub, uq, ur, flip, sa, sb;
			logic ng_a, ng_b;
			w = (wi > 64) ? 64 : wi;
			tw = (twi > 64) ? 64 : twi;
			m = ones_below(w);
			a = ai & m; b = bi & m; da = dai & m; db = dbi & m;
			both = da & db;
			all = (both == m) ? m : 0;
			val = 0; def = 0; rw = w; r.dz = 1'b0;
			case (code)
				OP_ADD: begin val = a + b; def = defined_to_first_hole(both, m); end
				OP_SUB: begin val = a - b; def = defined_to_first_hole(both, m); end
				OP_MUL: begin val = a * b; def = all; end
				OP_DIVU, OP_DIVS, OP_MODU, OP_MODS: begin
					if (b == 0)
						r.dz = 1'b1;
					else begin
						def = all;
						if (code == OP_DIVU)
							val = a / b;
						else if (code == OP_MODU)
							val = a % b;
						else begin
							ng_a = sign_at(a, w); ng_b = sign_at(b, w);
							ua = ng_a ? (-a & m) : a;
							ub = ng_b ? (-b & m) : b;
							uq = ua / ub; ur = ua % ub;
							if (code == OP_DIVS)
								val = ((ng_a ^ ng_b) ? -uq : uq) & m;
							else
								val = (ng_a ? -ur : ur) & m;
						end
					end
				end
				OP_SHL: begin val = (b >= w) ? 0 : (a << b); def = both; end
				OP_SHR, OP_SHRS: begin
					fill = (code == OP_SHRS && sign_at(a, w)) ? m : 0;
					val = (b >= w) ? fill : ((a >> b) | (fill & ~(m >> b)));
					def = all;
				end
				OP_AND: begin val = a & b; def = both; end
				OP_OR: begin val = a | b; def = both; end
				OP_XOR: begin val = a ^ b; def = both; end
				OP_NOT: begin val = ~a; def = da; end
				OP_ZX, OP_SX: begin
					from = (w < tw) ? w : tw;
					fm = ones_below(from);
					hi = ones_below(tw) & ~fm;
					rw = tw;
					if (code == OP_ZX) begin
						val = a & fm; def = (da & fm) | hi;
					end else if (w != 0 && tw != 0) begin
						val = (a & fm) | (sign_at(a, from) ? hi : 0);
						def = (da & fm) | (sign_at(da, from) ? hi : 0);
					end
				end
				OP_EQ, OP_NEQ, OP_LES, OP_LEU, OP_LTS, OP_LTU: begin
					flip = (w == 0) ? 0 : (64'd1 << (w - 1));
					sa = a ^ flip; sb = b ^ flip;
					rw = 1;
					def = (both == m) ? 1 : 0;
					case (code)
						OP_EQ: val = ((a & da) == (b & db));
						OP_NEQ: val = ((a & da) != (b & db));
						OP_LES: val = (sa <= sb);
						OP_LEU: val = (a <= b);
						OP_LTS: val = (sa < sb);
						default: val = (a < b);
					endcase
				end
				default: rw = 0;
			endcase
			r.value = val & ones_below(rw);
			r.defined = def & ones_below(rw);
			r.rwidth = rw[6:0];
			return r;
		endfunction

		function void note_request(logic [4:0] code, logic [6:0] wi, logic [6:0] twi,
				logic [63:0] ai, logic [63:0] dai, logic [63:0] bi, logic [63:0] dbi);
			pending.push_back(compute(code, wi, twi, ai, dai, bi, dbi));
		endfunction

		function void check_result(logic [63:0] v, logic [63:0] d, logic [6:0] rw,
				logic z);
			alu_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result value=%h defined=%h", v, d);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (v !== e.value || d !== e.defined || rw !== e.rwidth || z !== e.dz) begin
				errors++;
				if (errors <= 10)
					$display("mismatch #%0d: exp v=%h d=%h w=%0d dz=%b got v=%h d=%h w=%0d dz=%b",
						checked, e.value, e.defined, e.rwidth, e.dz, v, d, rw, z);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	awdt_req_if req();
	awdt_rsp_if rsp();
	alu_scoreboard results;
	int sent;
	int idle_pct_req;
	int idle_pct_rsp;
	bit holdoff;
	bit stim_done;
	int quiet_cycles;

	alu_with_definedness_tracking DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// scoreboard hooks: sample both channels at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				results.note_request(req.req_type, req.width, req.target_width,
					req.operand_a, req.defined_a, req.operand_b, req.defined_b);
			if (rsp.valid && rsp.ready)
				results.check_result(rsp.result_value, rsp.result_defined,
					rsp.result_width, rsp.divide_by_zero);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= 5000);
		$display("timeout after %0d quiet cycles", quiet_cycles);
		$display("tb_alu_with_definedness_tracking failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off to fill the pipe
	initial begin
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff)
				rsp.ready <= 0;
			else
				rsp.ready <= ($urandom_range(99) >= idle_pct_rsp);
		end
	end

	initial begin
		holdoff = 0;
		wait (sent >= 300);
		holdoff = 1;
		repeat (400) @(posedge clk);
		holdoff = 0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] shaped_mask();
		case ($urandom_range(3))
			0: return '1;
			1: return rand64();
			2: return ~(64'd1 << $urandom_range(63));
			default: return '1;
		endcase
	endfunction

	task automatic send_item(logic [4:0] code, logic [6:0] w, logic [6:0] tw,
			logic [63:0] a, logic [63:0] da, logic [63:0] b, logic [63:0] db);
		while ($urandom_range(99) < idle_pct_req) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.req_type <= code;
		req.width <= w;
		req.target_width <= tw;
		req.operand_a <= a;
		req.defined_a <= da;
		req.operand_b <= b;
		req.defined_b <= db;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_random();
		logic [4:0] code;
		logic [6:0] w;
		logic [63:0] a, b;
		code = ($urandom_range(49) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(21));
		case ($urandom_range(5))
			0: w = 7'($urandom_range(127));
			1: w = 7'd64;
			2: w = 7'($urandom_range(16));
			default: w = 7'($urandom_range(64));
		endcase
		a = rand64();
		b = rand64();
		if (code >= OP_SHL && code <= OP_SHRS && $urandom_range(3) != 0)
			b = 64'($urandom_range(70));
		if (code >= OP_DIVU && code <= OP_MODS && $urandom_range(7) == 0)
			b = 0;
		if (code == OP_EQ && $urandom_range(1))
			b = a;
		if ($urandom_range(7) == 0) begin
			a = 64'd1 << (w == 0 ? 0 : w - 1);
			b = '1;
		end
		send_item(code, w, 7'($urandom_range(127)), a, shaped_mask(), b, shaped_mask());
	endtask

	initial begin
		logic [63:0] ones;
		ones = '1;
		results = new();
		sent = 0;
		stim_done = 0;
		quiet_cycles = 0;
		idle_pct_req = 38;
		idle_pct_rsp = 38;
		req.valid = 0;
		req.req_type = OP_ADD;
		req.width = 0;
		req.target_width = 0;
		req.operand_a = 0;
		req.defined_a = 0;
		req.operand_b = 0;
		req.defined_b = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed corners
		send_item(OP_ADD, 64, 0, ones, ones, 64'd1, ones);
		send_item(OP_SUB, 64, 0, 0, 64'hffff_ff00_ffff_ffff, 64'd1, ones);
		send_item(OP_MUL, 64, 0, ones, ones, ones, ones);
		send_item(OP_DIVU, 64, 0, 64'd100, ones, 0, ones);
		send_item(OP_DIVS, 8, 0, 64'h80, ones, 64'hff, ones);
		send_item(OP_MODS, 8, 0, 64'h80, ones, 64'hff, ones);
		send_item(OP_MODS, 8, 0, 64'hf9, ones, 64'h02, ones);
		send_item(OP_MODU, 0, 0, 64'd5, ones, 64'd3, ones);
		send_item(OP_SHL, 16, 0, 64'hffff, 64'hff0f, 64'd16, ones);
		send_item(OP_SHR, 64, 0, ones, ones, 64'd63, ones);
		send_item(OP_SHRS, 32, 0, 64'h8000_0000, ones, 64'd40, ones);
		send_item(OP_SHRS, 32, 0, 64'h8000_0000, ones, 64'd4, 64'hfffe);
		send_item(OP_AND, 64, 0, ones, 64'h0f, ones, 64'hf3);
		send_item(OP_OR, 127, 0, ones, ones, 0, ones);
		send_item(OP_XOR, 5, 0, ones, ones, ones, ones);
		send_item(OP_NOT, 64, 0, 0, 64'hffff_0000_ffff_0000, 0, 0);
		send_item(OP_ZX, 8, 64, 64'h80, 64'h7f, 0, 0);
		send_item(OP_SX, 8, 64, 64'h80, 64'h7f, 0, 0);
		send_item(OP_SX, 0, 32, ones, ones, 0, 0);
		send_item(OP_SX, 32, 8, 64'h80, ones, 0, 0);
		send_item(OP_EQ, 8, 0, 64'h12, 64'h0f, 64'h22, 64'h0f);
		send_item(OP_NEQ, 64, 0, ones, ones, ones, ones);
		send_item(OP_LES, 8, 0, 64'h80, ones, 64'h7f, ones);
		send_item(OP_LEU, 8, 0, 64'h80, ones, 64'h7f, ones);
		send_item(OP_LTS, 0, 0, 0, 0, 0, 0);
		send_item(OP_LTU, 64, 0, 0, ones, ones, 64'h1);
		send_item(5'd31, 64, 64, ones, ones, ones, ones);
		// random, with an unstalled stretch in the middle
		for (int i = 0; i < 1400; i++) begin
			if (i == 600) begin
				idle_pct_req = 0;
				idle_pct_rsp = 0;
			end
			if (i == 850) begin
				idle_pct_req = 38;
				idle_pct_rsp = 38;
			end
			send_random();
		end
		req.valid <= 0;
		stim_done = 1;
		while (results.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		$display("sent %0d requests over all opcodes and widths, checked %0d results",
			sent, results.checked);
		$display("mismatches and unexpected results: %0d", results.errors);
		if (results.errors == 0)
			$display("tb_alu_with_definedness_tracking passed");
		else
			$display("tb_alu_with_definedness_tracking failed");
		$finish;
	end
endmodule
